// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMRM_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMRM_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/smrm_pkg.sv =====
`default_nettype none

package smrm_pkg;

    // Default ring depth
    localparam int DEPTH_DEFAULT = 64;

    // Field widths
    localparam int MSG_W  = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;
    localparam int QLEN_W = 7;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RESET = 2'd1;
    localparam logic [ACT_W-1:0] ACT_NEXT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DROP  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 3'd0;
    localparam logic [STAT_W-1:0] ST_MSG   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NONE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

    // Position unit operations
    localparam int POS_OP_W = 2;
    localparam logic [POS_OP_W-1:0] POS_INC = 2'd0;
    localparam logic [POS_OP_W-1:0] POS_DEC = 2'd1;
    localparam logic [POS_OP_W-1:0] POS_SUB = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [MSG_W-1:0] message;
    } req_t;

    typedef struct packed {
        logic [MSG_W-1:0]  message_out;
        logic [STAT_W-1:0] status;
        logic [QLEN_W-1:0] queue_length;
    } res_t;

endpackage

`default_nettype wire

// ===== src/smrm_ram.sv =====
`default_nettype none

module smrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/smrm_pos_unit.sv =====
`default_nettype none

module smrm_pos_unit
    import smrm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic [POS_OP_W-1:0]          op,
    input  wire logic [$clog2(2*DEPTH)-1:0]   a,
    input  wire logic [$clog2(2*DEPTH)-1:0]   b,
    output logic      [$clog2(2*DEPTH)-1:0]   y
);

    localparam int PW = $clog2(2*DEPTH);
    localparam logic [PW-1:0] POS_LAST = PW'(2*DEPTH-1);
    localparam logic [PW:0]   POS_MOD  = (PW+1)'(2*DEPTH);

    logic [PW:0] diff;

    // Modular difference a - b; adding the modulus fixes a borrow
    assign diff = (a >= b) ? ({1'b0, a} - {1'b0, b})
                           : ({1'b0, a} - {1'b0, b} + POS_MOD);

    // Positions wrap modulo twice the depth
    always_comb
    begin
        case (op)
            POS_INC: y = (a == POS_LAST) ? '0 : a + PW'(1);
            POS_DEC: y = (a == '0) ? POS_LAST : a - PW'(1);
            POS_SUB: y = diff[PW-1:0];
            default: y = a;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/selective_receive_mailbox.sv =====
// Selective-receive mailbox.
// Request channel (req_valid/req_ready/req_data): action 0 pushes a word,
// 1 restarts the scan just before the head, 2 returns the next word of the
// scan window, 3 drops the cursor's word, or the head word outside the window.
// Result channel (res_valid/res_ready/res_data): exactly one result per
// request, carrying the word (next only), a status and the queue length.
// One request is worked at a time; req_ready is high only while idle.
// From accept to result: push, reset scan and empty drop go straight to
// the finish state; next passes a check state, then a capture state when a
// word is read from the ring; a drop checks the cursor and, when it lies
// inside the window, moves each older word one slot by a read and a write
// through the single ring RAM port pair before it advances the head.
// The next request can be accepted the cycle after its result is loaded.
// A stalled result holds in the output register; a finished request waits
// in the finish state until the register frees, so nothing is lost.
// Reset zeroes head, tail, cursor and end: the ring is empty, needs no clear.
`default_nettype none

module selective_receive_mailbox
    import smrm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req_data,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res_data
);

    localparam int PW = $clog2(2*DEPTH);
    localparam int AW = $clog2(DEPTH);
    localparam int LW = (PW > QLEN_W) ? PW : QLEN_W;
    localparam logic [PW-1:0] DEPTH_POS = PW'(DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_NEXT_CHK  = 3'd1;
    localparam logic [2:0] S_NEXT_CAP  = 3'd2;
    localparam logic [2:0] S_DROP_CHK  = 3'd3;
    localparam logic [2:0] S_DROP_RD   = 3'd4;
    localparam logic [2:0] S_DROP_WR   = 3'd5;
    localparam logic [2:0] S_DROP_HEAD = 3'd6;
    localparam logic [2:0] S_FINISH    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [PW-1:0]    cursor_reg, cursor_next;
    logic [PW-1:0]    end_reg, end_next;
    logic [PW-1:0]    dist_reg, dist_next;
    logic [PW-1:0]    p_reg, p_next;
    logic [PW-1:0]    q_reg, q_next;
    logic [MSG_W-1:0] msg_reg, msg_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_data_reg, res_data_next;

    logic [POS_OP_W-1:0] alu_op;
    logic [PW-1:0]       alu_a, alu_b, alu_y;
    logic [PW-1:0]       len;
    logic [LW-1:0]       len_ext;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [MSG_W-1:0] ram_wdata, ram_rdata;

    logic req_fire, res_free, in_window;

    function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
        logic [PW-1:0] t;
        t = (p >= DEPTH_POS) ? p - DEPTH_POS : p;
        return t[AW-1:0];
    endfunction

    // Shared position unit, driven by the sequencer
    smrm_pos_unit #(.DEPTH(DEPTH)) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // Queue length, tail minus head
    smrm_pos_unit #(.DEPTH(DEPTH)) u_len (
        .op (POS_SUB),
        .a  (tail_reg),
        .b  (head_reg),
        .y  (len)
    );

    // Message ring
    smrm_ram #(.WIDTH(MSG_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign res_free  = !res_valid_reg || res_ready;
    assign in_window = (dist_reg != '0) && (dist_reg < len);
    assign len_ext   = LW'(len);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cursor_next    = cursor_reg;
        end_next       = end_reg;
        dist_next      = dist_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        msg_next       = msg_reg;
        stat_next      = stat_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        alu_op         = POS_INC;
        alu_a          = cursor_reg;
        alu_b          = head_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_of(tail_reg);
        ram_wdata      = req_data.message;
        ram_raddr      = slot_of(q_reg);

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    msg_next   = '0;
                    stat_next  = ST_DONE;
                    state_next = S_FINISH;
                    case (req_data.action)
                        ACT_PUSH:
                        begin
                            alu_op = POS_INC;
                            alu_a  = tail_reg;
                            if (len >= DEPTH_POS)
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                tail_next = alu_y;
                            end
                        end
                        ACT_RESET:
                        begin
                            alu_op      = POS_DEC;
                            alu_a       = head_reg;
                            cursor_next = alu_y;
                            end_next    = tail_reg;
                        end
                        ACT_NEXT:
                        begin
                            alu_op = POS_INC;
                            alu_a  = cursor_reg;
                            if (cursor_reg == end_reg)
                            begin
                                end_next = tail_reg;
                            end
                            else
                            begin
                                cursor_next = alu_y;
                            end
                            state_next = S_NEXT_CHK;
                        end
                        default:
                        begin
                            // drop: distance of the cursor from the head
                            alu_op    = POS_SUB;
                            alu_a     = cursor_reg;
                            alu_b     = head_reg;
                            dist_next = alu_y;
                            if (len == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DROP_CHK;
                            end
                        end
                    endcase
                end
            end
            S_NEXT_CHK:
            begin
                // read issued here lands in the next cycle
                ram_raddr = slot_of(cursor_reg);
                if (cursor_reg == end_reg)
                begin
                    stat_next  = ST_NONE;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_NEXT_CAP;
                end
            end
            S_NEXT_CAP:
            begin
                msg_next   = ram_rdata;
                stat_next  = ST_MSG;
                state_next = S_FINISH;
            end
            S_DROP_CHK:
            begin
                if (in_window)
                begin
                    alu_op     = POS_DEC;
                    alu_a      = cursor_reg;
                    p_next     = cursor_reg;
                    q_next     = alu_y;
                    state_next = S_DROP_RD;
                end
                else
                begin
                    state_next = S_DROP_HEAD;
                end
            end
            S_DROP_RD:
            begin
                ram_raddr  = slot_of(q_reg);
                state_next = S_DROP_WR;
            end
            S_DROP_WR:
            begin
                // move the older word up one slot, then step down
                ram_we    = 1'b1;
                ram_waddr = slot_of(p_reg);
                ram_wdata = ram_rdata;
                alu_op    = POS_DEC;
                alu_a     = q_reg;
                p_next    = q_reg;
                q_next    = alu_y;
                if (q_reg == head_reg)
                begin
                    state_next = S_DROP_HEAD;
                end
                else
                begin
                    state_next = S_DROP_RD;
                end
            end
            S_DROP_HEAD:
            begin
                alu_op     = POS_INC;
                alu_a      = head_reg;
                head_next  = alu_y;
                state_next = S_FINISH;
            end
            default:
            begin
                // S_FINISH: load the result once the output register frees
                if (res_free)
                begin
                    res_valid_next             = 1'b1;
                    res_data_next.message_out  = msg_reg;
                    res_data_next.status       = stat_reg;
                    res_data_next.queue_length = len_ext[QLEN_W-1:0];
                    state_next                 = S_IDLE;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cursor_reg    <= '0;
            end_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cursor_reg    <= cursor_next;
            end_reg       <= end_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        dist_reg     <= dist_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        msg_reg      <= msg_next;
        stat_reg     <= stat_next;
        res_data_reg <= res_data_next;
    end

endmodule

`default_nettype wire

// ===== src/smrm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module smrm_checker
    import smrm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire res_t res_data
);

    // A stalled result holds
    `SMRM_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_data), "stalled result changed")

    // One request in flight: busy right after an accept
    `SMRM_ASSERT_NXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready, "request accepted while busy")

    // Only a returned message carries a word
    `SMRM_ASSERT_IMP(a_msg_zero, clk, rst_n, res_valid && (res_data.status != ST_MSG), res_data.message_out == '0, "word on a result without a message")

    // Status stays within its defined codes
    `SMRM_ASSERT_IMP(a_status_code, clk, rst_n, res_valid, res_data.status <= ST_EMPTY, "undefined status code")

endmodule

bind selective_receive_mailbox smrm_checker u_smrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
    import smrm_pkg::*;

    localparam int RING        = DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_REQS = 630;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data  = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res_data;

    selective_receive_mailbox #(.DEPTH(RING)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data (res_data)
    );

    // Mailbox shadow: ring contents, which slots hold a pushed word, positions
    logic [MSG_W-1:0]  ring_words [RING];
    bit                slot_written [RING];
    logic [QLEN_W-1:0] head_pos = '0;
    logic [QLEN_W-1:0] tail_pos = '0;
    logic [QLEN_W-1:0] cursor_pos = '0;
    logic [QLEN_W-1:0] scan_end_pos = '0;

    res_t expected_replies [$];
    int   mismatches   = 0;
    int   sent_count   = 0;
    int   stall_cycles = 0;
    bit   idle_on      = 1'b0;
    res_t due;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int slot(input logic [QLEN_W-1:0] p);
        return int'(p) % RING;
    endfunction

    // Apply one request to the shadow mailbox and return the reply it earns
    function automatic res_t mailbox_apply(input req_t r);
        res_t o;
        logic [QLEN_W-1:0] len, offset, p, q;
        o = '0;
        len = tail_pos - head_pos;
        case (r.action)
            ACT_PUSH:
            begin
                if (len >= RING)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    ring_words[slot(tail_pos)] = r.message;
                    slot_written[slot(tail_pos)] = 1'b1;
                    tail_pos = tail_pos + 1'b1;
                    o.status = ST_DONE;
                end
            end
            ACT_RESET:
            begin
                cursor_pos = head_pos - 1'b1;
                scan_end_pos = tail_pos;
                o.status = ST_DONE;
            end
            ACT_NEXT:
            begin
                // at the scan end, a next widens the window to the tail
                if (cursor_pos == scan_end_pos)
                    scan_end_pos = tail_pos;
                else
                    cursor_pos = cursor_pos + 1'b1;
                if (cursor_pos == scan_end_pos)
                begin
                    o.status = ST_NONE;
                end
                else
                begin
                    o.status = ST_MSG;
                    o.message_out = ring_words[slot(cursor_pos)];
                end
            end
            default:
            begin
                if (len == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    // cursor strictly inside the window: older words slide up one
                    offset = cursor_pos - head_pos;
                    if (offset >= 1 && offset < len)
                    begin
                        p = cursor_pos;
                        for (int k = 0; k < offset; k++)
                        begin
                            q = p - 1'b1;
                            ring_words[slot(p)] = ring_words[slot(q)];
                            p = q;
                        end
                    end
                    head_pos = head_pos + 1'b1;
                    o.status = ST_DONE;
                end
            end
        endcase
        o.queue_length = tail_pos - head_pos;
        return o;
    endfunction

    // True when the request would read a ring slot that no push has filled
    function automatic bit reads_unwritten(input req_t r);
        logic [QLEN_W-1:0] len, offset, c, e, p;
        len = tail_pos - head_pos;
        c = cursor_pos;
        e = scan_end_pos;
        if (r.action == ACT_NEXT)
        begin
            if (c == e)
                e = tail_pos;
            else
                c = c + 1'b1;
            return (c != e) && !slot_written[slot(c)];
        end
        if (r.action == ACT_DROP && len != 0)
        begin
            offset = c - head_pos;
            if (offset >= 1 && offset < len)
            begin
                p = c;
                for (int k = 0; k < offset; k++)
                begin
                    p = p - 1'b1;
                    if (!slot_written[slot(p)])
                        return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Send one request; entered and left at a falling edge
    task automatic send_request(input logic [ACT_W-1:0] action, input logic [MSG_W-1:0] word);
        req_t r;
        int gap;
        r.action = action;
        r.message = word;
        // a full ring has every slot filled, so a push is always safe here
        if (reads_unwritten(r))
            r.action = ACT_PUSH;
        req_data <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_replies.push_back(mailbox_apply(r));
        sent_count++;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 11)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic [ACT_W-1:0] weighted_action(input int push_w, input int drop_w);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_w)
            return ACT_PUSH;
        if (roll < push_w + drop_w)
            return ACT_DROP;
        return roll[0] ? ACT_NEXT : ACT_RESET;
    endfunction

    // Empty mailbox: drop flags empty, scans find nothing
    task automatic test_empty_queue();
        send_request(ACT_DROP, '0);
        send_request(ACT_NEXT, '0);
        send_request(ACT_RESET, '0);
        send_request(ACT_NEXT, '0);
    endtask

    // Pushes with extreme and alternating word patterns
    task automatic test_push_extremes();
        send_request(ACT_PUSH, 32'h0000_0000);
        send_request(ACT_PUSH, 32'hFFFF_FFFF);
        send_request(ACT_PUSH, 32'hAAAA_AAAA);
        send_request(ACT_PUSH, 32'h5555_5555);
        send_request(ACT_PUSH, 32'h0000_0001);
        send_request(ACT_PUSH, 32'h8000_0000);
    endtask

    // Full scan to the end, then a push widens the window on the next next
    task automatic test_scan_window();
        send_request(ACT_RESET, '0);
        repeat (8) send_request(ACT_NEXT, '0);
        send_request(ACT_PUSH, $urandom);
        send_request(ACT_NEXT, '0);
    endtask

    // Drop inside the window, before the head, at the head, and stale reads
    task automatic test_drop_cases();
        send_request(ACT_RESET, '0);
        repeat (3) send_request(ACT_NEXT, '0);
        send_request(ACT_DROP, '0);
        send_request(ACT_RESET, '0);
        send_request(ACT_DROP, '0);
        send_request(ACT_RESET, '0);
        send_request(ACT_NEXT, '0);
        send_request(ACT_DROP, '0);
        send_request(ACT_RESET, '0);
        repeat (2) send_request(ACT_NEXT, '0);
        repeat (2) send_request(ACT_DROP, '0);
        repeat (2) send_request(ACT_NEXT, '0);
    endtask

    // Fill to full and past it, drop at the deepest cursor, drain to empty
    task automatic test_fill_to_full();
        idle_on = 1'b0;
        while (tail_pos != head_pos)
            send_request(ACT_DROP, '0);
        for (int i = 0; i < RING + 2; i++)
            send_request(ACT_PUSH, $urandom);
        send_request(ACT_RESET, '0);
        repeat (RING) send_request(ACT_NEXT, '0);
        send_request(ACT_DROP, '0);
        send_request(ACT_NEXT, '0);
        send_request(ACT_RESET, '0);
        repeat (RING / 2) send_request(ACT_NEXT, '0);
        while (tail_pos != head_pos)
            send_request(ACT_DROP, '0);
        send_request(ACT_DROP, '0);
        idle_on = 1'b1;
    endtask

    // Random traffic in phases: filling, draining, noise and receive scans
    task automatic test_random_traffic();
        int first, mode, scans;
        first = sent_count;
        while (sent_count - first < RANDOM_REQS)
        begin
            mode = $urandom_range(0, 4);
            idle_on = ($urandom_range(0, 5) != 0);
            repeat (30)
            begin
                if (sent_count - first >= RANDOM_REQS)
                    break;
                case (mode)
                    0: send_request(weighted_action(70, 10), $urandom);
                    1: send_request(weighted_action(10, 60), $urandom);
                    2: send_request(ACT_W'($urandom_range(0, 3)), $urandom);
                    default:
                    begin
                        // selective receive: rescan, walk some words, take one
                        send_request(ACT_RESET, $urandom);
                        scans = $urandom_range(0, int'(QLEN_W'(tail_pos - head_pos)) + 1);
                        repeat (scans) send_request(ACT_NEXT, $urandom);
                        if ($urandom_range(0, 4) != 0)
                            send_request(ACT_DROP, $urandom);
                        if ($urandom_range(0, 1) != 0)
                            send_request(ACT_PUSH, $urandom);
                    end
                endcase
            end
        end
        idle_on = 1'b1;
    endtask

    // Result side back-pressure
    always @(negedge clk)
        res_ready <= !(idle_on && $urandom_range(0, 99) < 11);

    // Compare each reply with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: reply with none expected: %p", $time, res_data);
            end
            else
            begin
                due = expected_replies.pop_front();
                if (res_data.message_out !== due.message_out)
                begin
                    mismatches++;
                    $display("%0t: message_out expected %h, got %h",
                             $time, due.message_out, res_data.message_out);
                end
                if (res_data.status !== due.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, due.status, res_data.status);
                end
                if (res_data.queue_length !== due.queue_length)
                begin
                    mismatches++;
                    $display("%0t: queue_length expected %0d, got %0d",
                             $time, due.queue_length, res_data.queue_length);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            stall_cycles <= 0;
        else if (rst_n)
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("selective_receive_mailbox regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_on = 1'b1;
        test_empty_queue();
        test_push_extremes();
        test_scan_window();
        test_drop_cases();
        test_fill_to_full();
        test_random_traffic();
        req_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("selective_receive_mailbox regression: pass");
        else
            $display("selective_receive_mailbox regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
